### rtl/core/simple_regex_stream_matcher_macros.svh
// Assertion macros for the simple regex stream matcher checker.
// Used by the checker file only; no other dependencies.
`ifndef SIMPLE_REGEX_STREAM_MATCHER_MACROS_SVH
`define SIMPLE_REGEX_STREAM_MATCHER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define SRSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srsm check failed");

// Consequent must hold in the cycle after the antecedent, reset included.
`define SRSM_ASSERT_NEXT_RAW(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("srsm check failed");

`endif

### rtl/core/srsm_pkg.sv
// Shared constants and types for the simple regex stream matcher.
// No dependencies; imported by the cell and the top level.
package srsm_pkg;

    localparam int PATTERN_MAX_DEF = 16;

    // Pattern metacharacters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    // Bits handed from one cell to the next. near_* is meant for the
    // receiving cell, far_* for the one after it; relay_* is the far_*
    // of the cell two places back, passed on by the sender.
    typedef struct packed {
        logic near_step;
        logic far_step;
        logic far_cl1;
        logic far_cl2;
        logic relay_step;
        logic relay_cl1;
        logic relay_cl2;
    } t_link;

endpackage

### rtl/core/srsm_cell.sv
// One pattern position of the matcher: decodes its element, holds no state,
// and ripples closure and step bits to its neighbours. Uses srsm_pkg.
module srsm_cell #(
    parameter int IDX = 0,
    parameter int LW  = 5
) (
    input  logic [LW-1:0]       i_len,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_next_byte,
    input  logic [7:0]          i_text,
    input  logic                i_seed,
    input  logic                i_active,
    input  srsm_pkg::t_link     i_link,
    output srsm_pkg::t_link     o_link,
    output logic                o_cur,
    output logic                o_nxt,
    output logic                o_end
);
    import srsm_pkg::*;

    typedef enum logic [1:0] {K_DEAD, K_BYTE, K_STAR, K_END} t_kind;

    localparam logic [LW:0] POS  = (LW+1)'(IDX);
    localparam logic [LW:0] POS1 = (LW+1)'(IDX + 1);

    t_kind      kind;
    logic [7:0] ch;
    logic       any_byte;
    logic       far;
    logic       valid;
    logic       has_next;
    logic       last;
    logic       hit;
    logic       c1;
    logic       n;
    logic       is_star;
    logic       is_byte;
    logic       self_loop;

    assign valid    = POS  < {1'b0, i_len};
    assign has_next = POS1 < {1'b0, i_len};
    assign last     = POS1 == {1'b0, i_len};

    always_comb begin
        kind     = K_BYTE;
        ch       = i_byte;
        any_byte = 1'b0;
        far      = 1'b0;
        if (i_byte == CH_BSLASH) begin
            // escape: next byte literal, or a dead end at the pattern tail
            if (has_next) begin
                ch  = i_next_byte;
                far = 1'b1;
            end else begin
                kind = K_DEAD;
            end
        end else if (has_next && i_next_byte == CH_STAR) begin
            kind     = K_STAR;
            any_byte = i_byte == CH_DOT;
        end else if (i_byte == CH_DOLLAR && last) begin
            kind = K_END;
        end else begin
            any_byte = i_byte == CH_DOT;
        end
    end

    assign hit     = any_byte | (ch == i_text);
    assign is_star = valid & (kind == K_STAR);
    assign is_byte = valid & (kind == K_BYTE);

    // closed set of live positions before the byte
    assign c1        = i_active | i_seed | i_link.relay_cl1;
    assign self_loop = c1 & is_star & hit;
    // closed set after the byte
    assign n = i_link.near_step | i_link.relay_step | self_loop | i_link.relay_cl2;

    assign o_link.near_step  = c1 & is_byte & hit & ~far;
    assign o_link.far_step   = c1 & is_byte & hit & far;
    assign o_link.far_cl1    = c1 & is_star;
    assign o_link.far_cl2    = n & is_star;
    assign o_link.relay_step = i_link.far_step;
    assign o_link.relay_cl1  = i_link.far_cl1;
    assign o_link.relay_cl2  = i_link.far_cl2;

    assign o_cur = c1;
    assign o_nxt = n;
    assign o_end = c1 & valid & (kind == K_END);

endmodule

### rtl/core/simple_regex_stream_matcher.sv
// Top level of the simple regex stream matcher: APB register file, state
// registers and the row of srsm_cell positions. Uses srsm_pkg and srsm_cell.
//
// Usage
//   Program the pattern through the APB port: register 0 (address 0) holds
//   pattern bytes 0..7, register 1 (address 8) bytes 8..15, register 2
//   (address 16) the length. Write only between texts or between items.
//   Stream text on the slave channel: tuser low carries one byte in tdata,
//   tuser high marks the end of the text and carries no byte.
//   For every end-of-text item one result item leaves on the master channel,
//   tdata bit 0 set when the text matched. Byte items give no result.
// Latency and throughput
//   One item is taken per cycle while the result slot is free or draining;
//   the result of an end-of-text item is shown in the cycle after it is
//   accepted. The cycle is bounded by the two closure ripples through the
//   row of cells (before and after the byte), each PATTERN_MAX+1 cells long.
// Reset and stalls
//   Reset clears the pattern, the live positions and the result valid flag.
//   A held result stays put while the receiver stalls; tready drops then
//   and every input item, byte or end of text, waits until the result is
//   taken. A result taken in the same cycle frees the slot at once.
module simple_regex_stream_matcher #(
    parameter int PATTERN_MAX = srsm_pkg::PATTERN_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // text stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tuser,   // [0] func (1 = end of text)
    // result stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [0] matched, [7:1] zero
);
    import srsm_pkg::*;

    localparam int LW    = $clog2(PATTERN_MAX + 1);
    localparam int NCELL = PATTERN_MAX + 1;

    localparam logic [1:0] REG_LO  = 2'd0;
    localparam logic [1:0] REG_HI  = 2'd1;
    localparam logic [1:0] REG_LEN = 2'd2;

    localparam logic FUNC_END = 1'b1;

    logic [63:0]      r_pat_lo;
    logic [63:0]      r_pat_hi;
    logic [4:0]       r_len;
    logic [NCELL-1:0] r_active;
    logic [NCELL-1:0] n_active;
    logic             r_found;
    logic             n_found;
    logic             r_at_start;
    logic             n_at_start;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_matched;
    logic             n_matched;

    logic [127:0]     pat;
    logic [LW-1:0]    len_eff;
    logic             anchored;
    logic [NCELL-1:0] seed;
    logic [NCELL-1:0] cur_vec;
    logic [NCELL-1:0] nxt_vec;
    logic [NCELL-1:0] end_vec;
    t_link            links [NCELL+1];
    logic             in_acc;
    logic             cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_LO:  r_pat_lo <= pwdata;
                REG_HI:  r_pat_hi <= pwdata;
                REG_LEN: r_len    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_LO:  prdata = r_pat_lo;
            REG_HI:  prdata = r_pat_hi;
            REG_LEN: prdata = {59'd0, r_len};
            default: prdata = '0;
        endcase
    end

    // ---------------- pattern view ----------------
    assign pat      = {r_pat_hi, r_pat_lo};
    // clamp an oversized length to the row size
    assign len_eff  = (r_len > 5'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : r_len[LW-1:0];
    assign anchored = (len_eff != '0) && (pat[7:0] == CH_CARET);

    // start position: 0 normally, 1 past the caret only at text start
    always_comb begin
        seed    = '0;
        seed[0] = ~anchored;
        seed[1] = anchored & r_at_start;
    end

    // ---------------- row of cells ----------------
    assign links[0] = '0;

    for (genvar p = 0; p < NCELL; p++) begin : g_cell
        logic [7:0] byte_p;
        logic [7:0] byte_n;
        if (p < 16) begin : g_b
            assign byte_p = pat[8*p +: 8];
        end else begin : g_nb
            assign byte_p = 8'h00;
        end
        if (p + 1 < 16) begin : g_n
            assign byte_n = pat[8*(p+1) +: 8];
        end else begin : g_nn
            assign byte_n = 8'h00;
        end
        srsm_cell #(
            .IDX (p),
            .LW  (LW)
        ) u_cell (
            .i_len       (len_eff),
            .i_byte      (byte_p),
            .i_next_byte (byte_n),
            .i_text      (i_s_axis_tdata),
            .i_seed      (seed[p]),
            .i_active    (r_active[p]),
            .i_link      (links[p]),
            .o_link      (links[p+1]),
            .o_cur       (cur_vec[p]),
            .o_nxt       (nxt_vec[p]),
            .o_end       (end_vec[p])
        );
    end

    // ---------------- handshake and state ----------------
    // skid-free: take input whenever the result slot is free or draining
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;

    always_comb begin
        n_active    = r_active;
        n_found     = r_found;
        n_at_start  = r_at_start;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_matched   = r_matched;
        if (in_acc) begin
            if (i_s_axis_tuser == FUNC_END) begin
                // report, then drop back to the start of a new text
                n_out_valid = 1'b1;
                n_matched   = r_found | cur_vec[len_eff] | (|end_vec);
                n_active    = '0;
                n_found     = 1'b0;
                n_at_start  = 1'b1;
            end else begin
                n_active   = nxt_vec;
                n_found    = r_found | cur_vec[len_eff] | nxt_vec[len_eff];
                n_at_start = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_found     <= 1'b0;
            r_at_start  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_found     <= n_found;
            r_at_start  <= n_at_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_matched};

endmodule

### rtl/core/srsm_checker.sv
// Port-level checker for the simple regex stream matcher, bound to the top.
// Depends on simple_regex_stream_matcher_macros.svh.
`include "simple_regex_stream_matcher_macros.svh"

module srsm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       i_s_axis_tuser,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);
    // a stalled result holds its value
    `SRSM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // an accepted end of text shows a result next cycle
    `SRSM_ASSERT_NEXT(a_end_result, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser, o_m_axis_tvalid)
    // a byte item never invents a result
    `SRSM_ASSERT_NEXT(a_byte_quiet, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser && !o_m_axis_tvalid, !o_m_axis_tvalid)
    // reset empties the result slot
    `SRSM_ASSERT_NEXT_RAW(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind simple_regex_stream_matcher srsm_checker u_srsm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### bench/tb_simple_regex_stream_matcher.sv
`timescale 1ns / 100ps
// Self-checking bench for simple_regex_stream_matcher: programs patterns over APB,
// streams texts in, and checks each match flag against an in-bench automaton.
// Depends on srsm_pkg and the matcher RTL only.
module tb_simple_regex_stream_matcher;

    import srsm_pkg::*;

    // Register map: three 64-bit registers at 8-byte strides
    localparam logic [4:0] REG_PATTERN_LOW  = 5'd0;
    localparam logic [4:0] REG_PATTERN_HIGH = 5'd8;
    localparam logic [4:0] REG_PATTERN_LEN  = 5'd16;

    // Item kinds carried on tuser
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    localparam int          RESET_CYCLES    = 9;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          HOLD_OFF_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    // Element kinds of a decoded pattern position
    typedef enum logic [1:0] {
        K_DEAD,
        K_BYTE,
        K_STAR,
        K_END
    } t_pat_kind;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [4:0]  paddr           = '0;
    logic [63:0] pwdata          = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;  // [7:0] text_byte
    logic        i_s_axis_tuser  = 1'b0; // [0] func (1 = end of text)
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;         // [0] matched, [7:1] zero

    simple_regex_stream_matcher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the pattern registers and of the automaton state
    logic [63:0] pat_low_q  = '0;
    logic [63:0] pat_high_q = '0;
    logic [4:0]  pat_len_q  = '0;
    logic [16:0] live_q     = '0;   // live pattern positions
    logic        seen_q     = 1'b0; // match already seen in this text
    logic        fresh_q    = 1'b1; // no byte of this text yet

    logic        match_flags_q[$];  // match flags still to come out

    // Bench knobs and statistics
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_off_seq   = 0;
    int          hold_off_seen  = 0;
    int          hold_off_left  = 0;
    int unsigned cycle_count    = 0;
    int          fail_count     = 0;
    int          items_sent     = 0;
    int          texts_sent     = 0;
    int          texts_matched  = 0;
    int          pattern_loads  = 0;

    // ------------------------------------------------------------------
    // Automaton
    // ------------------------------------------------------------------

    function automatic logic [7:0] pat_char(input int unsigned i);
        int unsigned j;
        j = i & 15;
        if (j < 8)
            return pat_low_q[8*j +: 8];
        return pat_high_q[8*(j-8) +: 8];
    endfunction

    // Lengths above the row size behave as a full row
    function automatic int unsigned used_len();
        return (pat_len_q > 5'd16) ? 16 : int'(pat_len_q);
    endfunction

    function automatic t_pat_kind decode_element(input int unsigned p, input int unsigned len,
                                                 output logic [7:0] ch, output logic any,
                                                 output int unsigned nx);
        logic [7:0] b;
        b   = pat_char(p);
        any = 1'b0;
        ch  = 8'h00;
        nx  = p + 1;
        // An escape consumes the next byte whatever it is, even a star
        if (b == CH_BSLASH) begin
            if (p + 1 < len) begin
                ch = pat_char(p + 1);
                nx = p + 2;
                return K_BYTE;
            end
            return K_DEAD;
        end
        if (p + 1 < len && pat_char(p + 1) == CH_STAR) begin
            ch  = b;
            any = (b == CH_DOT);
            nx  = p + 2;
            return K_STAR;
        end
        if (b == CH_DOLLAR && p + 1 == len)
            return K_END;
        ch  = b;
        any = (b == CH_DOT);
        return K_BYTE;
    endfunction

    // Starred elements may be skipped: propagate forward in one ascending pass
    function automatic logic [31:0] close_stars(input logic [31:0] v, input int unsigned len);
        logic [7:0]  ch;
        logic        any;
        int unsigned nx;
        for (int unsigned p = 0; p < len; p++) begin
            if (v[p] && decode_element(p, len, ch, any, nx) == K_STAR)
                v[nx] = 1'b1;
        end
        return v;
    endfunction

    // Advance the shadow automaton by one accepted item; queue a flag on end of text
    task automatic advance_matcher(input logic func, input logic [7:0] text_byte);
        int unsigned len;
        int unsigned nx;
        logic [7:0]  ch;
        logic        any;
        t_pat_kind   kind;
        logic [31:0] cur;
        logic [31:0] nxt;
        len = used_len();
        cur = {15'd0, live_q};
        // Unanchored patterns may start anywhere; '^' only at the first byte
        if (len > 0 && pat_char(0) == CH_CARET) begin
            if (fresh_q)
                cur[1] = 1'b1;
        end else begin
            cur[0] = 1'b1;
        end
        cur = close_stars(cur, len);
        if (cur[len])
            seen_q = 1'b1;
        if (func == FUNC_END) begin
            for (int unsigned p = 0; p < len; p++) begin
                if (cur[p] && decode_element(p, len, ch, any, nx) == K_END)
                    seen_q = 1'b1;
            end
            match_flags_q.push_back(seen_q);
            live_q  = '0;
            seen_q  = 1'b0;
            fresh_q = 1'b1;
        end else begin
            nxt = '0;
            for (int unsigned p = 0; p < len; p++) begin
                if (cur[p]) begin
                    kind = decode_element(p, len, ch, any, nx);
                    if (kind == K_BYTE && (any || ch == text_byte))
                        nxt[nx] = 1'b1;
                    else if (kind == K_STAR && (any || ch == text_byte))
                        nxt[p] = 1'b1;
                end
            end
            nxt = close_stars(nxt, len);
            if (nxt[len])
                seen_q = 1'b1;
            live_q  = nxt[16:0];
            fresh_q = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Values read right after the edge are those the block sampled at it
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            advance_matcher(i_s_axis_tuser, i_s_axis_tdata);
    end

    always @(posedge i_clk) begin
        logic expected;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (match_flags_q.size() == 0) begin
                $error("result with no expectation waiting: matched %0d", o_m_axis_tdata[0]);
                fail_count++;
            end else begin
                expected = match_flags_q.pop_front();
                if (o_m_axis_tdata[0] !== expected) begin
                    $error("matched: expected %0d, actual %0d", expected, o_m_axis_tdata[0]);
                    fail_count++;
                end
                if (expected)
                    texts_matched++;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when the test asks for one
    always @(posedge i_clk) begin
        if (hold_off_seen != hold_off_seq) begin
            hold_off_seen   <= hold_off_seq;
            hold_off_left   <= HOLD_OFF_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left   <= hold_off_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, match_flags_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Setup then access phase; pready is sampled in the access phase
    task automatic write_reg(input logic [4:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            REG_PATTERN_LOW:  pat_low_q  = data;
            REG_PATTERN_HIGH: pat_high_q = data;
            REG_PATTERN_LEN:  pat_len_q  = data[4:0];
            default: ;
        endcase
        // Return to idle before any further transfer
        @(posedge i_clk);
    endtask

    task automatic load_pattern_regs(input logic [63:0] low, input logic [63:0] high,
                                     input logic [4:0] len);
        write_reg(REG_PATTERN_LOW, low);
        write_reg(REG_PATTERN_HIGH, high);
        write_reg(REG_PATTERN_LEN, {59'd0, len});
        pattern_loads++;
    endtask

    task automatic load_pattern(input string pat, input logic [4:0] len);
        logic [127:0] bytes;
        bytes = '0;
        for (int i = 0; i < pat.len() && i < 16; i++)
            bytes[8*i +: 8] = pat[i];
        load_pattern_regs(bytes[63:0], bytes[127:64], len);
    endtask

    // Offer one item, idling first at random; valid stays high until the
    // next gap so that back-to-back items never lower and raise it in one step
    task automatic send_item(input logic func, input logic [7:0] text_byte);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= text_byte;
        i_s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        items_sent++;
        if (func == FUNC_END)
            texts_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_item(FUNC_BYTE, text[i]);
        send_item(FUNC_END, 8'h00);
    endtask

    // Drop valid, hold until every flag is back, then let the row settle
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (match_flags_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------

    function automatic logic [7:0] random_meta();
        case ($urandom_range(0, 4))
            0:       return CH_BSLASH;
            1:       return CH_STAR;
            2:       return CH_DOLLAR;
            3:       return CH_DOT;
            default: return CH_CARET;
        endcase
    endfunction

    // Pattern bytes lean on a small alphabet so that texts actually match
    function automatic logic [7:0] random_pattern_char();
        int r;
        r = $urandom_range(0, 15);
        if (r <= 5)  return "a";
        if (r <= 8)  return "b";
        if (r == 9)  return CH_DOT;
        if (r <= 11) return CH_STAR;
        if (r == 12) return CH_BSLASH;
        if (r == 13) return CH_CARET;
        if (r == 14) return CH_DOLLAR;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] random_text_char();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5) return "a";
        if (r <= 7) return "b";
        if (r == 8) return random_meta();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic load_random_pattern();
        logic [127:0] bytes;
        int           len;
        int           r;
        bytes = '0;
        r     = $urandom_range(0, 19);
        if (r == 0) begin
            // Raw register contents, every bit free
            load_pattern_regs({$urandom, $urandom}, {$urandom, $urandom},
                              5'($urandom_range(0, 31)));
        end else if (r == 1) begin
            load_pattern_regs('1, '1, 5'($urandom_range(0, 1) ? 16 : 31));
        end else if (r == 2) begin
            load_pattern_regs('0, '0, 5'd0);
        end else begin
            // Mostly short patterns, now and then a longer one up to a full row
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            for (int i = 0; i < 16; i++)
                bytes[8*i +: 8] = random_pattern_char();
            if ($urandom_range(0, 4) == 0)
                bytes[7:0] = CH_CARET;
            if ($urandom_range(0, 4) == 0)
                bytes[8*(len-1) +: 8] = CH_DOLLAR;
            load_pattern_regs(bytes[63:0], bytes[127:64], 5'(len));
        end
    endtask

    task automatic send_random_text();
        int len;
        if ($urandom_range(0, 9) == 0) begin
            // Noise: raw bytes of any value
            len = $urandom_range(0, 20);
            repeat (len) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
        end else begin
            len = $urandom_range(0, 10);
            repeat (len) send_item(FUNC_BYTE, random_text_char());
        end
        send_item(FUNC_END, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pattern registers at their reset value: empty pattern matches anything
    task automatic test_empty_pattern();
        send_text("");
        send_text("zq");
        wait_drained();
    endtask

    task automatic test_special_patterns();
        // End anchor
        load_pattern("ab$", 5'd3);
        send_text("xab");
        // Start anchor with a starred element
        wait_drained();
        load_pattern("^a*b", 5'd4);
        send_text("aab");
        send_text("cb");
        // Escaped star after a wildcard; extreme byte; bytes after an early match
        wait_drained();
        load_pattern(".\\*", 5'd3);
        send_text("\377*z");
        // Lone trailing backslash never matches
        wait_drained();
        load_pattern("a\\", 5'd2);
        send_text("a");
        // Escape takes one byte only; the star that follows is literal
        wait_drained();
        load_pattern("\\a*", 5'd3);
        send_text("a*");
        // Dollar not last and caret not first are literals
        wait_drained();
        load_pattern("a$^", 5'd3);
        send_text("a$^");
        // Star with nothing before it is a literal
        wait_drained();
        load_pattern("*a", 5'd2);
        send_text("*a");
        // Oversized length: the whole row is used, the final dollar still anchors
        wait_drained();
        load_pattern("a*a*a*a*a*a*a*x$", 5'd31);
        send_text("ax");
        send_text("axa");
        wait_drained();
    endtask

    // Hold the receiver off so that results back up and the input stalls
    task automatic test_stall_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_pattern("a*b", 5'd3);
        hold_off_seq++;
        repeat (30) send_text("b");
        wait_drained();
        // Bursts with the sender pausing until every flag is back
        repeat (4) begin
            repeat (5) send_random_text();
            wait_drained();
        end
    endtask

    task automatic test_random_texts();
        int idle_modes[4][2] = '{'{0, 0}, '{52, 0}, '{0, 52}, '{38, 38}};
        int target;
        foreach (idle_modes[m]) begin
            send_idle_pct  = idle_modes[m][0];
            recv_stall_pct = idle_modes[m][1];
            target = items_sent + 440;
            while (items_sent < target) begin
                wait_drained();
                load_random_pattern();
                repeat ($urandom_range(4, 12)) send_random_text();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pattern();
        test_special_patterns();
        test_stall_pressure();
        test_random_texts();

        // Drain, then allow the pipeline to go quiet
        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        $display("Sent %0d items in %0d texts over %0d pattern loads; %0d texts matched.",
                 items_sent, texts_sent, pattern_loads, texts_matched);
        $display("Idle mixes: none, sender 52%%, receiver 52%%, both 38%%; one long hold-off.");
        if (fail_count == 0 && match_flags_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
